>>> hw/rtl/aes_pkg.sv
package aes_pkg;

   // round counts are at most 14, so four bits hold them
   localparam int ROUND_W = 4;

   // configuration register indexes
   localparam logic [2:0] REG_KEY_WORD_0   = 3'd0;
   localparam logic [2:0] REG_KEY_WORD_1   = 3'd1;
   localparam logic [2:0] REG_KEY_WORD_2   = 3'd2;
   localparam logic [2:0] REG_KEY_WORD_3   = 3'd3;
   localparam logic [2:0] REG_KEY_LENGTH   = 3'd4;
   localparam logic [2:0] REG_DECRYPT_MODE = 3'd5;

   // key length codes; every other code runs as a 256 bit key
   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;

   localparam logic [ROUND_W-1:0] ROUNDS_128 = 4'd10;
   localparam logic [ROUND_W-1:0] ROUNDS_192 = 4'd12;
   localparam logic [ROUND_W-1:0] ROUNDS_256 = 4'd14;

   localparam logic [3:0] NK_128 = 4'd4;
   localparam logic [3:0] NK_192 = 4'd6;
   localparam logic [3:0] NK_256 = 4'd8;

   localparam logic [7:0] GF_POLY    = 8'h1B;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_word_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_word_type;

   // shift control for the round key chain
   typedef struct packed {
      logic fwd;
      logic bwd;
   } chain_ctl_type;

   // round key handed from the expander to the chain
   typedef struct packed {
      logic         push;
      logic         last;
      logic [127:0] key;
   } kx_out_type;

   typedef enum logic [2:0] {
      ST_KICK,
      ST_EXPAND,
      ST_ALIGN,
      ST_IDLE,
      ST_RUN
   } ctl_state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
      8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
      8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
      8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
      8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
      8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
      8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
      8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
      8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
      8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
      8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
      8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
      8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
      8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
      8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
   };

   // multiply by x in GF(2^8)
   function automatic logic [7:0] xt(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
   endfunction

   // SubBytes then ShiftRows; byte n sits at bits 127-8n downward
   function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127-8*(r+4*c) -: 8] = SBOX[s[127-8*(r+4*((c+r)&3)) -: 8]];
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
      logic [127:0] o;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127-8*(r+4*c) -: 8] = INV_SBOX[s[127-8*(r+4*((c-r)&3)) -: 8]];
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] mix_col_fwd(input logic [31:0] a);
      logic [7:0] a0, a1, a2, a3;
      a0 = a[31:24];
      a1 = a[23:16];
      a2 = a[15:8];
      a3 = a[7:0];
      return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
              xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
   endfunction

   // products by 9, 11, 13 and 14 from a doubling chain
   function automatic logic [31:0] mix_col_inv(input logic [31:0] a);
      logic [7:0] b [4];
      logic [7:0] m9 [4];
      logic [7:0] m11 [4];
      logic [7:0] m13 [4];
      logic [7:0] m14 [4];
      logic [7:0] x2, x4, x8;
      for (int k = 0; k < 4; k++) begin
         b[k]   = a[31-8*k -: 8];
         x2     = xt(b[k]);
         x4     = xt(x2);
         x8     = xt(x4);
         m9[k]  = x8 ^ b[k];
         m11[k] = x8 ^ x2 ^ b[k];
         m13[k] = x8 ^ x4 ^ b[k];
         m14[k] = x8 ^ x4 ^ x2;
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
   endfunction

   function automatic logic [127:0] mix_fwd_block(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         o[127-32*c -: 32] = mix_col_fwd(s[127-32*c -: 32]);
      end
      return o;
   endfunction

   function automatic logic [127:0] mix_inv_block(input logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         o[127-32*c -: 32] = mix_col_inv(s[127-32*c -: 32]);
      end
      return o;
   endfunction

endpackage

>>> hw/rtl/aes_block_cipher.sv
// One block at a time: no input word is taken until the previous result is in the output
// register. The round key ring turns once per block, one slot per cycle, and the round
// unit consumes the head slot.
// Key schedule: rerun after reset and after every write to a defined register (index 0 to 5),
// followed for encryption, where needed, by alignment turns of the ring; no input word is taken then.
// Reset (synchronous, active high) clears the configuration registers to zero and reloads the zero key.
module aes_block_cipher import aes_pkg::*; #(
   parameter int ROUND_KEY_SLOTS = 15
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   localparam int CNT_W = $clog2(ROUND_KEY_SLOTS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUND_KEY_SLOTS);
   localparam logic [CNT_W-1:0] CNT_WRAP = CNT_W'(ROUND_KEY_SLOTS - 1);

   ctl_state_type       state_ff, state_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;
   logic [127:0]        st_ff, st_in;
   logic [3:0][63:0]    key_word_ff;
   logic [1:0]          key_length_ff;
   logic                decrypt_ff;

   logic                write_now;
   logic                accept;
   logic                kick;
   logic [ROUND_W-1:0]  full_rounds;
   logic [ROUND_W-1:0]  rounds;
   kx_out_type          kx;
   chain_ctl_type       ctl;
   logic [127:0]        top_in;
   logic [127:0]        key_q [ROUND_KEY_SLOTS];
   logic [127:0]        round_out;

   // configuration registers
   assign write_now = csr_we && csr_index <= REG_DECRYPT_MODE;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word_ff   <= '0;
         key_length_ff <= '0;
         decrypt_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_KEY_WORD_0:   key_word_ff[0] <= csr_wdata;
            REG_KEY_WORD_1:   key_word_ff[1] <= csr_wdata;
            REG_KEY_WORD_2:   key_word_ff[2] <= csr_wdata;
            REG_KEY_WORD_3:   key_word_ff[3] <= csr_wdata;
            REG_KEY_LENGTH:   key_length_ff  <= csr_wdata[1:0];
            REG_DECRYPT_MODE: decrypt_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // round count, cut to what the ring can hold
   always_comb begin
      case (key_length_ff)
         KEY_LEN_128: full_rounds = ROUNDS_128;
         KEY_LEN_192: full_rounds = ROUNDS_192;
         default:     full_rounds = ROUNDS_256;
      endcase
      rounds = (full_rounds > ROUND_W'(ROUND_KEY_SLOTS - 1)) ?
               ROUND_W'(ROUND_KEY_SLOTS - 1) : full_rounds;
   end

   aes_kexp u_kexp (
      .clock      (clock),
      .reset      (reset),
      .start      (kick),
      .key_words  (key_word_ff),
      .key_length (key_length_ff),
      .decrypt    (decrypt_ff),
      .rounds     (rounds),
      .kx         (kx)
   );

   // round key ring; new keys enter at the top (encrypt) or bottom (decrypt)
   assign top_in = (state_ff == ST_EXPAND) ? kx.key : key_q[0];

   for (genvar g = 0; g < ROUND_KEY_SLOTS; g++) begin : g_cell
      logic [127:0] up_key;
      logic [127:0] down_key;
      if (g == ROUND_KEY_SLOTS - 1) begin : g_top
         assign up_key = top_in;
      end else begin : g_mid
         assign up_key = key_q[g+1];
      end
      if (g == 0) begin : g_bot
         assign down_key = kx.key;
      end else begin : g_low
         assign down_key = key_q[g-1];
      end
      aes_kcell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .up_key   (up_key),
         .down_key (down_key),
         .key      (key_q[g])
      );
   end

   aes_round u_round (
      .state     (st_ff),
      .round_key (key_q[0]),
      .decrypt   (decrypt_ff),
      .last      (cnt_ff == CNT_W'(rounds)),
      .result    (round_out)
   );

   assign accept = req_valid && !req_stall;

   // control: key schedule, alignment, block rounds and output hand-off
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff | write_now;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kick         = 1'b0;
      ctl          = '0;
      req_stall    = !(state_ff == ST_IDLE && !pend_ff);
      case (state_ff)
         ST_KICK: begin
            kick     = 1'b1;
            pend_in  = write_now;
            state_in = ST_EXPAND;
         end
         ST_EXPAND: begin
            if (pend_ff) begin
               state_in = ST_KICK;
            end else if (kx.push) begin
               ctl.fwd = !decrypt_ff;
               ctl.bwd = decrypt_ff;
               if (kx.last) begin
                  cnt_in = CNT_W'(rounds) + 1'b1;
                  if (decrypt_ff || CNT_W'(rounds) == CNT_WRAP) begin
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_ALIGN;
                  end
               end
            end
         end
         ST_ALIGN: begin
            if (pend_ff) begin
               state_in = ST_KICK;
            end else begin
               ctl.fwd = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == CNT_WRAP) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (pend_ff) begin
               state_in = ST_KICK;
            end else if (accept) begin
               ctl.fwd  = 1'b1;
               st_in    = req_data ^ key_q[0];
               cnt_in   = CNT_W'(1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_ff != CNT_LAST) begin
               ctl.fwd = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff <= CNT_W'(rounds)) begin
                  st_in = round_out;
               end
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = st_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_KICK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KICK;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a taken word always starts the round count at one
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_RUN && cnt_ff == CNT_W'(1))
      else $error("run did not start after accept");

   // the ring turns every cycle until the last slot
   a_run_advances: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff != CNT_LAST)
      |=> state_ff == ST_RUN && cnt_ff == CNT_W'($past(cnt_ff) + 1'b1))
      else $error("round counter stalled mid block");

   // a result appears only out of a finished run
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RUN && $past(cnt_ff) == CNT_LAST)
      else $error("result without a finished run");

   // the last round key never arrives while a block runs
   a_last_key: assert property (@(posedge clock) disable iff (reset)
      kx.last |-> state_ff == ST_EXPAND || state_ff == ST_KICK
                  || state_ff == ST_ALIGN || state_ff == ST_IDLE)
      else $error("round key pushed during a block");

endmodule

>>> hw/rtl/aes_kcell.sv
// one slot of the round key ring
module aes_kcell import aes_pkg::*; (
   input  logic          clock,
   input  chain_ctl_type ctl,
   input  logic [127:0]  up_key,
   input  logic [127:0]  down_key,
   output logic [127:0]  key
);

   logic [127:0] key_ff;
   logic [127:0] key_in;

   // fwd takes the upper neighbor, bwd the lower one
   always_comb begin
      key_in = key_ff;
      if (ctl.fwd) begin
         key_in = up_key;
      end else if (ctl.bwd) begin
         key_in = down_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

>>> hw/rtl/aes_kexp.sv
// key schedule: one 32-bit word per cycle, a round key every fourth word
module aes_kexp import aes_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [3:0][63:0]        key_words,
   input  logic [1:0]              key_length,
   input  logic                    decrypt,
   input  logic [ROUND_W-1:0]      rounds,
   output kx_out_type              kx
);

   logic                 busy_ff, busy_in;
   logic [5:0]           idx_ff, idx_in;
   logic [2:0]           phase_ff, phase_in;
   logic [7:0]           rcon_ff, rcon_in;
   logic [95:0]          acc_ff, acc_in;
   logic [7:0][31:0]     win_ff, win_in;

   logic [3:0]           nk;
   logic [2:0]           base;
   logic [7:0][31:0]     kwords;
   logic [31:0]          tmp;
   logic [31:0]          word;
   logic [ROUND_W-1:0]   kidx;
   logic [127:0]         rkey;

   always_comb begin
      case (key_length)
         KEY_LEN_128: nk = NK_128;
         KEY_LEN_192: nk = NK_192;
         default:     nk = NK_256;
      endcase
      base = 3'(NK_256 - nk);
      for (int k = 0; k < 8; k++) begin
         kwords[k] = key_words[k/2][63-32*(k%2) -: 32];
      end
   end

   // next schedule word
   always_comb begin
      tmp = win_ff[7];
      if (phase_ff == 3'd0) begin
         tmp = {SBOX[win_ff[7][23:16]] ^ rcon_ff, SBOX[win_ff[7][15:8]],
                SBOX[win_ff[7][7:0]], SBOX[win_ff[7][31:24]]};
      end else if (nk == NK_256 && phase_ff == 3'd4) begin
         tmp = {SBOX[win_ff[7][31:24]], SBOX[win_ff[7][23:16]],
                SBOX[win_ff[7][15:8]], SBOX[win_ff[7][7:0]]};
      end
      if (idx_ff < 6'(nk)) begin
         word = win_ff[3'(base + idx_ff[2:0])];
      end else begin
         word = tmp ^ win_ff[base];
      end
   end

   // assembled round key, inverse-mixed for the middle decrypt rounds
   always_comb begin
      kidx = idx_ff[5:2];
      rkey = {acc_ff, word};
      if (decrypt && kidx != '0 && kidx != rounds) begin
         rkey = mix_inv_block({acc_ff, word});
      end
      kx.push = busy_ff && idx_ff[1:0] == 2'd3;
      kx.last = kx.push && kidx == rounds;
      kx.key  = rkey;
   end

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      rcon_in  = rcon_ff;
      acc_in   = acc_ff;
      win_in   = win_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         phase_in = '0;
         rcon_in  = RCON_FIRST;
         for (int m = 0; m < 8; m++) begin
            win_in[m] = kwords[3'(m) - base];
         end
      end else if (busy_ff) begin
         idx_in = idx_ff + 6'd1;
         acc_in = {acc_ff[63:0], word};
         if (idx_ff >= 6'(nk)) begin
            win_in   = {word, win_ff[7:1]};
            phase_in = (phase_ff == 3'(nk - 4'd1)) ? 3'd0 : phase_ff + 3'd1;
            if (phase_ff == 3'd0) begin
               rcon_in = xt(rcon_ff);
            end
         end
         if (kx.last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
      rcon_ff  <= rcon_in;
      acc_ff   <= acc_in;
      win_ff   <= win_in;
   end

endmodule

>>> hw/rtl/aes_round.sv
// one cipher round, forward or equivalent inverse
module aes_round import aes_pkg::*; (
   input  logic [127:0] state,
   input  logic [127:0] round_key,
   input  logic         decrypt,
   input  logic         last,
   output logic [127:0] result
);

   logic [127:0] ss;
   logic [127:0] mixed;

   always_comb begin
      if (decrypt) begin
         ss    = sub_shift_inv(state);
         mixed = last ? ss : mix_inv_block(ss);
      end else begin
         ss    = sub_shift_fwd(state);
         mixed = last ? ss : mix_fwd_block(ss);
      end
      result = mixed ^ round_key;
   end

endmodule

>>> tb/tb_aes_block_cipher.sv
`timescale 1ns / 1ps

module tb_aes_block_cipher;
   import aes_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;

   aes_block_cipher uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   localparam int KEY_SLOTS = 15;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [1:0] KEY_LEN_256 = 2'd2;

   // predictor copy of the configuration and round keys
   logic [63:0]  key_words [4];
   logic [1:0]   key_len_code;
   logic         decrypt_on;
   logic [127:0] sched_keys [KEY_SLOTS];
   int           round_count;

   req_word_type pending_words [$];
   rsp_word_type expected_blocks [$];
   int           error_count;
   int           idle_cycles;
   bit           idling_on;
   bit           hold_sender;
   bit           req_taken;
   int           send_gap;
   int           stall_run;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [7:0] gf2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc ^= a;
         a = gf2(a);
      end
      return acc;
   endfunction

   function automatic logic [7:0] sb_at(input logic [127:0] s, input int n);
      return s[127-8*n -: 8];
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inv);
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = sb_at(s, 4*c); a1 = sb_at(s, 4*c+1); a2 = sb_at(s, 4*c+2); a3 = sb_at(s, 4*c+3);
         if (!inv) begin
            o[127-32*c -: 32] = {gf_mul(a0,2)^gf_mul(a1,3)^a2^a3, a0^gf_mul(a1,2)^gf_mul(a2,3)^a3,
                                 a0^a1^gf_mul(a2,2)^gf_mul(a3,3), gf_mul(a0,3)^a1^a2^gf_mul(a3,2)};
         end else begin
            o[127-32*c -: 32] = {
               gf_mul(a0,14)^gf_mul(a1,11)^gf_mul(a2,13)^gf_mul(a3,9),
               gf_mul(a0,9)^gf_mul(a1,14)^gf_mul(a2,11)^gf_mul(a3,13),
               gf_mul(a0,13)^gf_mul(a1,9)^gf_mul(a2,14)^gf_mul(a3,11),
               gf_mul(a0,11)^gf_mul(a1,13)^gf_mul(a2,9)^gf_mul(a3,14)};
         end
      end
      return o;
   endfunction

   // substitution and row shift; inverse table built by searching the forward one
   function automatic logic [127:0] subst_shift(input logic [127:0] s, input bit inv);
      logic [127:0] o;
      logic [7:0]   v;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            if (!inv) begin
               o[127-8*(r+4*c) -: 8] = SBOX[sb_at(s, r + 4*((c+r)&3))];
            end else begin
               v = sb_at(s, r + 4*c);
               for (int k = 0; k < 256; k++) begin
                  if (SBOX[k] == v) o[127-8*(r+4*((c+r)&3)) -: 8] = k[7:0];
               end
            end
         end
      end
      return o;
   endfunction

   task automatic build_round_keys();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rc;
      int          nk, total;
      nk = (key_len_code == KEY_LEN_128) ? 4 : (key_len_code == KEY_LEN_192) ? 6 : 8;
      round_count = nk + 6;
      if (round_count + 1 > KEY_SLOTS) round_count = KEY_SLOTS - 1;
      total = 4 * (nk + 7);
      rc = 8'h01;
      for (int i = 0; i < nk; i++) w[i] = key_words[i>>1][63-32*(i&1) -: 32];
      for (int i = nk; i < total; i++) begin
         t = w[i-1];
         if (i % nk == 0) begin
            t = {SBOX[t[23:16]] ^ rc, SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]};
            rc = gf2(rc);
         end else if (nk > 6 && i % nk == 4) begin
            t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
         end
         w[i] = t ^ w[i-nk];
      end
      for (int r = 0; r <= round_count; r++)
         sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
      if (decrypt_on)
         for (int r = 1; r < round_count; r++) sched_keys[r] = mix_columns(sched_keys[r], 1'b1);
   endtask

   function automatic rsp_word_type cipher_block(input req_word_type d);
      logic [127:0] s;
      rsp_word_type o;
      s = {d.block_high, d.block_low};
      if (!decrypt_on) begin
         s ^= sched_keys[0];
         for (int r = 1; r < round_count; r++)
            s = mix_columns(subst_shift(s, 1'b0), 1'b0) ^ sched_keys[r];
         s = subst_shift(s, 1'b0) ^ sched_keys[round_count];
      end else begin
         s ^= sched_keys[round_count];
         for (int r = round_count - 1; r >= 1; r--)
            s = mix_columns(subst_shift(s, 1'b1), 1'b1) ^ sched_keys[r];
         s = subst_shift(s, 1'b1) ^ sched_keys[0];
      end
      o.result_high = s[127:64];
      o.result_low  = s[63:0];
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // register write at one rising edge, then update the predictor
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_KEY_WORD_0:   key_words[0] = val;
         REG_KEY_WORD_1:   key_words[1] = val;
         REG_KEY_WORD_2:   key_words[2] = val;
         REG_KEY_WORD_3:   key_words[3] = val;
         REG_KEY_LENGTH:   key_len_code = val[1:0];
         REG_DECRYPT_MODE: decrypt_on = val[0];
         default: return;
      endcase
      build_round_keys();
   endtask

   task automatic drain();
      wait (pending_words.size() == 0 && expected_blocks.size() == 0);
      repeat (KEY_SLOTS + 4) @(negedge clock);
   endtask

   task automatic load_key(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [1:0] len, input bit dec);
      drain();
      write_reg(REG_KEY_WORD_0, k0);
      write_reg(REG_KEY_WORD_1, k1);
      write_reg(REG_KEY_WORD_2, k2);
      write_reg(REG_KEY_WORD_3, k3);
      write_reg(REG_KEY_LENGTH, {62'd0, len});
      write_reg(REG_DECRYPT_MODE, {63'd0, dec});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic queue_word(input logic [63:0] hi, input logic [63:0] lo);
      req_word_type d;
      d.block_high = hi;
      d.block_low  = lo;
      pending_words.push_back(d);
   endtask

   // accept seen at the rising edge, used by the driver at the next falling edge
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // driver: sender side
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken) void'(pending_words.pop_front());
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (hold_sender || pending_words.size() == 0
                      || (idling_on && $urandom_range(0, 9) == 0)) begin
            req_valid <= 1'b0;
            if (idling_on && pending_words.size() != 0 && !hold_sender)
               send_gap <= $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_words[0];
         end
      end
   end

   // receiver stall bursts
   always @(negedge clock) begin
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_run <= $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on input accept, check on output accept
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) expected_blocks.push_back(cipher_block(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_blocks.size() == 0) begin
               report_mismatch("unexpected word", rsp_data.result_high, 64'd0);
            end else begin
               if (rsp_data.result_high !== expected_blocks[0].result_high)
                  report_mismatch("result_high", rsp_data.result_high,
                                  expected_blocks[0].result_high);
               if (rsp_data.result_low !== expected_blocks[0].result_low)
                  report_mismatch("result_low", rsp_data.result_low,
                                  expected_blocks[0].result_low);
               void'(expected_blocks.pop_front());
            end
         end
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = REG_KEY_WORD_0;
      csr_wdata = '0;
      error_count = 0;
      idling_on = 1'b1;
      hold_sender = 1'b0;
      send_gap = 0;
      stall_run = 0;
      foreach (key_words[i]) key_words[i] = '0;
      key_len_code = KEY_LEN_128;
      decrypt_on = 1'b0;
      build_round_keys();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset key, field extremes
      queue_word(64'd0, 64'd0);
      queue_word('1, '1);
      queue_word(64'h8000000000000000, 64'h1);
      // standard vectors: 128 bit encrypt, 192 bit decrypt and 256 bit encrypt
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
               64'h18191a1b1c1d1e1f, KEY_LEN_128, 1'b0);
      queue_word(64'h0011223344556677, 64'h8899aabbccddeeff);
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
               64'h18191a1b1c1d1e1f, KEY_LEN_192, 1'b1);
      queue_word(64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
      queue_word('1, 64'd0);
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
               64'h18191a1b1c1d1e1f, KEY_LEN_256, 1'b0);
      queue_word(64'h0011223344556677, 64'h8899aabbccddeeff);
      // unused length code runs as a 256 bit key; all-ones key
      load_key('1, '1, '1, '1, 2'd3, 1'b1);
      queue_word(64'd0, '1);
      queue_word(rand64(), rand64());
      // out-of-range index must be ignored
      drain();
      write_reg(3'd6, rand64());
      write_reg(3'd7, rand64());
      queue_word(64'h0123456789abcdef, 64'hfedcba9876543210);

      // random phases, each under a fresh key
      for (int ph = 0; ph < 20; ph++) begin
         if (ph == 16) begin
            drain();
            idling_on = 1'b0;
         end
         load_key(rand64(), rand64(), rand64(), rand64(),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         for (int n = 0; n < 30; n++) begin
            if (n == 15 && ph == 3) begin
               // hold input until everything in flight has come back
               hold_sender = 1'b1;
               wait (pending_words.size() == 0 || expected_blocks.size() == 0);
               wait (expected_blocks.size() == 0);
               hold_sender = 1'b0;
            end
            queue_word(rand64(), rand64());
         end
      end

      wait (pending_words.size() == 0 && expected_blocks.size() == 0);
      repeat (KEY_SLOTS + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> aes_block_cipher.f
hw/rtl/aes_pkg.sv
hw/rtl/aes_kcell.sv
hw/rtl/aes_kexp.sv
hw/rtl/aes_round.sv
hw/rtl/aes_block_cipher.sv
tb/tb_aes_block_cipher.sv
